### src/bta_pkg.sv
package bta_pkg;

  localparam int unsigned HEAP_BYTES    = 65536;
  localparam int unsigned GRANULE_BYTES = 16;
  localparam int unsigned CHUNK_BYTES   = 4096;

  localparam int unsigned HDR      = GRANULE_BYTES;
  localparam int unsigned MINB     = 2 * GRANULE_BYTES;
  localparam int unsigned WORDS    = HEAP_BYTES / 8;
  localparam int unsigned WALK_MAX = HEAP_BYTES / MINB + 1;

  localparam int unsigned AW   = 17;
  localparam int unsigned VW   = 22;
  localparam int unsigned DW   = 64;
  localparam int unsigned WIDX = $clog2(WORDS);
  localparam int unsigned KW   = $clog2(WALK_MAX + 1);
  localparam int unsigned TW   = 21;

  typedef logic [VW-1:0] val_t;
  typedef logic [AW-1:0] addr_t;

  localparam val_t HDR_V    = VW'(HDR);
  localparam val_t MINB_V   = VW'(MINB);
  localparam val_t HEAP_V   = VW'(HEAP_BYTES);
  localparam val_t CHUNK_V  = VW'(CHUNK_BYTES);
  localparam val_t HI_V     = VW'(8);
  localparam val_t GMASK_V  = VW'(GRANULE_BYTES - 1);
  localparam logic [TW-1:0] THR_RESET = TW'(131072);

  localparam logic [2:0] F_ALLOC = 3'b001;
  localparam logic [2:0] F_PREV  = 3'b010;
  localparam logic [2:0] F_MMAP  = 3'b100;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_DFREE = 2'd2,
    ST_LARGE = 2'd3
  } status_e;

  typedef struct packed {
    op_e         operation;
    logic [19:0] request_bytes;
    addr_t       payload_address;
  } in_req_t;

  typedef struct packed {
    addr_t   result_address;
    status_e status;
  } out_rsp_t;

  typedef struct packed {
    logic          re;
    logic          we;
    val_t          addr;
    logic [DW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    val_t a;
    val_t b;
  } alu_req_t;

  typedef struct packed {
    val_t sum;
    val_t diff;
    logic lt;
  } alu_rsp_t;

  typedef enum logic [6:0] {
    S_IDLE, S_CHK, S_CUT_INIT, S_CUT_HEAD, S_CUT_SZ, S_CUT_FL, S_CUT_NEXT, S_CUT_FIT,
    S_SP_HDR, S_SP_FLG, S_SP_RDP, S_SP_RDX, S_SP_WRP, S_SP_WRX, S_SP_LP, S_SP_LX,
    S_SP_BLK, S_SP_BFL, S_NS_CHK, S_NS_CLR, S_NS_UL, S_CUT_HIT, S_CUT_MISS,
    S_GR_INIT, S_GR_CHK, S_GR_HEAD, S_GR_TEST, S_GR_NEXT, S_GF_RD, S_GF_WR, S_GF_DONE,
    S_GN_HDR, S_GN_FLG, S_F_CHK, S_F_SZ, S_F_FL, S_F_NX, S_F_NFL, S_F_NSZ, S_F_MRG,
    S_F_PV, S_F_PSZ, S_F_PRD, S_F_PWR, S_F_CLR, S_F_CLW, S_FIN, S_DONE,
    S_CF0, S_CF1, S_CF2, S_CF3, S_UL0, S_UL1, S_UL2, S_UL3, S_UL4, S_UL5,
    S_IN0, S_IN1, S_IN2, S_IN3, S_IN4, S_IN5, S_IN6
  } state_e;

endpackage

### src/boundary_tag_heap_allocator_core.sv
// boundary tag heap allocator, first fit over a lifo free list kept in heap memory
// in channel: in_valid_i / in_ready_o carry one allocate or free request
// out channel: out_valid_o / out_ready_i carry one result per request
// config: cfg_we_i writes cfg_wdata_i to the large request threshold
// one request is worked at a time by a sequencer around one adder/comparator
// and a single-port heap ram with a registered read
// allocate: a first fit walk over the free list; when the
// arena has to grow, a search for the free block at the arena top, then a second walk
// free: the work depends on how many neighbors are merged
// a refused (large), null or bad free request ends early, without a list walk
// the list walk, with its ram reads for every node, sets the allocate latency
// reset empties the free list and the arena; heap ram is not cleared, every
// word is written before the sequencer reads it
// the result sits in an output register; a new request is taken while it
// waits, and the next result waits in its last state until that one is taken
module boundary_tag_heap_allocator_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  bta_pkg::in_req_t        in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output bta_pkg::out_rsp_t       out_data_o,
  input  logic                    cfg_we_i,
  input  logic [bta_pkg::TW-1:0]  cfg_wdata_i
);
  import bta_pkg::*;

  state_e state_q, state_d;
  state_e cf_ret_q, cf_ret_d, ul_ret_q, ul_ret_d, ins_ret_q, ins_ret_d;

  logic [19:0]   req_q, req_d;
  val_t          addr_q, addr_d;
  logic [TW-1:0] thr_q;
  addr_t         head_q, head_d;
  val_t          top_q, top_d, ntop_q, ntop_d;
  val_t          need_q, need_d, chunk_q, chunk_d;
  addr_t         n_q, n_d, p_q, p_d, x_q, x_d;
  val_t          blk_q, blk_d, sz_q, sz_d, nsz_q, nsz_d, r_q, r_d, rem_q, rem_d;
  val_t          nx_q, nx_d;
  logic [2:0]    fl_q, fl_d;
  logic          nfl_q, nfl_d;
  logic [KW-1:0] k_q, k_d;
  logic          pass_q, pass_d;
  addr_t         res_q, res_d;
  status_e       st_q, st_d;
  val_t          cf_b_q, cf_b_d, cf_sz_q, cf_sz_d, cf_fa_q, cf_fa_d;
  logic [2:0]    cf_fl_q, cf_fl_d;
  addr_t         ul_n_q, ul_n_d, ul_p_q, ul_p_d, ul_x_q, ul_x_d;
  val_t          ins_b_q, ins_b_d;
  logic          out_valid_q, out_valid_d;
  out_rsp_t      out_q, out_d;

  mem_req_t      mreq;
  logic [DW-1:0] rdata;
  val_t          rd_v;
  alu_req_t      areq;
  alu_rsp_t      arsp;
  val_t          rnd;

  bta_heap_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .rdata_o(rdata)
  );

  bta_alu u_alu (
    .req_i(areq),
    .rsp_o(arsp)
  );

  assign rd_v = rdata[VW-1:0];
  assign rnd  = (VW'(req_q) + GMASK_V) & ~GMASK_V;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cf_ret_q    <= S_IDLE;
      ul_ret_q    <= S_IDLE;
      ins_ret_q   <= S_IDLE;
      thr_q       <= THR_RESET;
      head_q      <= '0;
      top_q       <= '0;
      pass_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cf_ret_q    <= cf_ret_d;
      ul_ret_q    <= ul_ret_d;
      ins_ret_q   <= ins_ret_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      top_q       <= top_d;
      pass_q      <= pass_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;   addr_q  <= addr_d;
    ntop_q  <= ntop_d;  need_q  <= need_d;  chunk_q <= chunk_d;
    n_q     <= n_d;     p_q     <= p_d;     x_q     <= x_d;
    blk_q   <= blk_d;   sz_q    <= sz_d;    nsz_q   <= nsz_d;
    r_q     <= r_d;     rem_q   <= rem_d;   nx_q    <= nx_d;
    fl_q    <= fl_d;    nfl_q   <= nfl_d;   res_q   <= res_d;
    st_q    <= st_d;    cf_b_q  <= cf_b_d;  cf_sz_q <= cf_sz_d;
    cf_fa_q <= cf_fa_d; cf_fl_q <= cf_fl_d; ul_n_q  <= ul_n_d;
    ul_p_q  <= ul_p_d;  ul_x_q  <= ul_x_d;  ins_b_q <= ins_b_d;
    out_q   <= out_d;
  end

  always_comb begin
    state_d = state_q;  cf_ret_d = cf_ret_q; ul_ret_d = ul_ret_q; ins_ret_d = ins_ret_q;
    req_d = req_q; addr_d = addr_q; head_d = head_q; top_d = top_q;
    ntop_d = ntop_q; need_d = need_q; chunk_d = chunk_q; n_d = n_q; p_d = p_q; x_d = x_q;
    blk_d = blk_q; sz_d = sz_q; nsz_d = nsz_q; r_d = r_q; rem_d = rem_q; nx_d = nx_q;
    fl_d = fl_q; nfl_d = nfl_q; k_d = k_q; pass_d = pass_q; res_d = res_q; st_d = st_q;
    cf_b_d = cf_b_q; cf_sz_d = cf_sz_q; cf_fa_d = cf_fa_q; cf_fl_d = cf_fl_q;
    ul_n_d = ul_n_q; ul_p_d = ul_p_q; ul_x_d = ul_x_q; ins_b_d = ins_b_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o = 1'b0;
    mreq = '0;
    areq = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d  = in_data_i.request_bytes;
          addr_d = VW'(in_data_i.payload_address);
          pass_d = 1'b0;
          state_d = (in_data_i.operation == OP_FREE) ? S_F_CHK : S_CHK;
        end
      end
      S_CHK: begin
        if ({1'b0, req_q} >= thr_q) begin
          st_d = ST_LARGE; res_d = '0; state_d = S_DONE;
        end else begin
          need_d = ((rnd + HDR_V) < MINB_V) ? MINB_V : (rnd + HDR_V);
          state_d = S_CUT_INIT;
        end
      end
      // first fit walk
      S_CUT_INIT: begin
        n_d = head_q; k_d = '0; state_d = S_CUT_HEAD;
      end
      S_CUT_HEAD: begin
        if (n_q == '0 || k_q >= KW'(WALK_MAX)) begin
          state_d = S_CUT_MISS;
        end else begin
          areq.a = VW'(n_q); areq.b = HDR_V;
          blk_d = arsp.diff;
          mreq.re = 1'b1; mreq.addr = arsp.diff;
          state_d = S_CUT_SZ;
        end
      end
      S_CUT_SZ: begin
        sz_d = rd_v; mreq.re = 1'b1; mreq.addr = blk_q | HI_V; state_d = S_CUT_FL;
      end
      S_CUT_FL: begin
        fl_d = rdata[2:0];
        areq.a = sz_q; areq.b = need_q;
        if (arsp.lt) begin
          mreq.re = 1'b1; mreq.addr = VW'(n_q) | HI_V;
          k_d = k_q + 1'b1;
          state_d = S_CUT_NEXT;
        end else begin
          rem_d = arsp.diff; state_d = S_CUT_FIT;
        end
      end
      S_CUT_NEXT: begin
        n_d = rdata[AW-1:0]; state_d = S_CUT_HEAD;
      end
      S_CUT_FIT: begin
        if (rem_q >= MINB_V) begin
          areq.a = blk_q; areq.b = need_q; r_d = arsp.sum; state_d = S_SP_HDR;
        end else begin
          areq.a = blk_q; areq.b = sz_q; nx_d = arsp.sum;
          mreq.we = 1'b1; mreq.addr = blk_q | HI_V; mreq.wdata = DW'(fl_q | F_ALLOC);
          state_d = S_NS_CHK;
        end
      end
      // split: the remainder takes the list slot
      S_SP_HDR: begin
        mreq.we = 1'b1; mreq.addr = r_q; mreq.wdata = DW'(rem_q); state_d = S_SP_FLG;
      end
      S_SP_FLG: begin
        mreq.we = 1'b1; mreq.addr = r_q | HI_V; mreq.wdata = '0;
        cf_b_d = r_q; cf_ret_d = S_SP_RDP; state_d = S_CF0;
      end
      S_SP_RDP: begin
        mreq.re = 1'b1; mreq.addr = VW'(n_q); state_d = S_SP_RDX;
      end
      S_SP_RDX: begin
        p_d = rdata[AW-1:0]; mreq.re = 1'b1; mreq.addr = VW'(n_q) | HI_V;
        state_d = S_SP_WRP;
      end
      S_SP_WRP: begin
        x_d = rdata[AW-1:0];
        areq.a = r_q; areq.b = HDR_V;
        mreq.we = 1'b1; mreq.addr = arsp.sum; mreq.wdata = DW'(p_q);
        state_d = S_SP_WRX;
      end
      S_SP_WRX: begin
        areq.a = r_q; areq.b = HDR_V;
        mreq.we = 1'b1; mreq.addr = arsp.sum | HI_V; mreq.wdata = DW'(x_q);
        state_d = S_SP_LP;
      end
      S_SP_LP: begin
        areq.a = r_q; areq.b = HDR_V;
        if (p_q != '0) begin
          mreq.we = 1'b1; mreq.addr = VW'(p_q) | HI_V; mreq.wdata = DW'(arsp.sum);
        end else begin
          head_d = arsp.sum[AW-1:0];
        end
        state_d = S_SP_LX;
      end
      S_SP_LX: begin
        areq.a = r_q; areq.b = HDR_V;
        if (x_q != '0) begin
          mreq.we = 1'b1; mreq.addr = VW'(x_q); mreq.wdata = DW'(arsp.sum);
        end
        state_d = S_SP_BLK;
      end
      S_SP_BLK: begin
        mreq.we = 1'b1; mreq.addr = blk_q; mreq.wdata = DW'(need_q); state_d = S_SP_BFL;
      end
      S_SP_BFL: begin
        mreq.we = 1'b1; mreq.addr = blk_q | HI_V;
        mreq.wdata = DW'((fl_q & (F_PREV | F_MMAP)) | F_ALLOC);
        state_d = S_CUT_HIT;
      end
      // exact fit: clear the right neighbor's prev-free bit, unlink
      S_NS_CHK: begin
        if (nx_q < top_q) begin
          mreq.re = 1'b1; mreq.addr = nx_q | HI_V; state_d = S_NS_CLR;
        end else begin
          state_d = S_NS_UL;
        end
      end
      S_NS_CLR: begin
        mreq.we = 1'b1; mreq.addr = nx_q | HI_V; mreq.wdata = rdata & ~DW'(F_PREV);
        state_d = S_NS_UL;
      end
      S_NS_UL: begin
        ul_n_d = n_q; ul_ret_d = S_CUT_HIT; state_d = S_UL0;
      end
      S_CUT_HIT: begin
        res_d = n_q; st_d = ST_OK; state_d = S_DONE;
      end
      S_CUT_MISS: begin
        if (pass_q) begin
          res_d = '0; st_d = ST_OOM; state_d = S_DONE;
        end else begin
          state_d = S_GR_INIT;
        end
      end
      // arena growth
      S_GR_INIT: begin
        chunk_d = ((need_q + CHUNK_V - 1'b1) / CHUNK_V) * CHUNK_V;
        if (chunk_d < CHUNK_V) chunk_d = CHUNK_V;
        state_d = S_GR_CHK;
      end
      S_GR_CHK: begin
        areq.a = top_q; areq.b = chunk_q;
        if (arsp.sum > HEAP_V) begin
          res_d = '0; st_d = ST_OOM; state_d = S_DONE;
        end else begin
          ntop_d = arsp.sum; n_d = head_q; k_d = '0; state_d = S_GR_HEAD;
        end
      end
      S_GR_HEAD: begin
        if (n_q == '0 || k_q >= KW'(WALK_MAX)) begin
          state_d = S_GN_HDR;
        end else begin
          areq.a = VW'(n_q); areq.b = HDR_V;
          blk_d = arsp.diff; mreq.re = 1'b1; mreq.addr = arsp.diff;
          state_d = S_GR_TEST;
        end
      end
      S_GR_TEST: begin
        areq.a = blk_q; areq.b = rd_v;
        if (arsp.sum == top_q) begin
          state_d = S_GF_RD;
        end else begin
          mreq.re = 1'b1; mreq.addr = VW'(n_q) | HI_V; k_d = k_q + 1'b1;
          state_d = S_GR_NEXT;
        end
      end
      S_GR_NEXT: begin
        n_d = rdata[AW-1:0]; state_d = S_GR_HEAD;
      end
      S_GF_RD: begin
        mreq.re = 1'b1; mreq.addr = blk_q; state_d = S_GF_WR;
      end
      S_GF_WR: begin
        areq.a = rd_v; areq.b = chunk_q;
        mreq.we = 1'b1; mreq.addr = blk_q; mreq.wdata = DW'(arsp.sum);
        cf_b_d = blk_q; cf_ret_d = S_GF_DONE; state_d = S_CF0;
      end
      S_GF_DONE: begin
        top_d = ntop_q; pass_d = 1'b1; state_d = S_CUT_INIT;
      end
      S_GN_HDR: begin
        blk_d = top_q;
        mreq.we = 1'b1; mreq.addr = top_q; mreq.wdata = DW'(chunk_q);
        state_d = S_GN_FLG;
      end
      S_GN_FLG: begin
        mreq.we = 1'b1; mreq.addr = blk_q | HI_V; mreq.wdata = '0;
        top_d = ntop_q; ins_b_d = blk_q; ins_ret_d = S_GF_DONE; state_d = S_IN0;
      end
      // free
      S_F_CHK: begin
        areq.a = addr_q; areq.b = HDR_V;
        if (addr_q == '0) begin
          res_d = '0; st_d = ST_OK; state_d = S_DONE;
        end else if (arsp.lt || (addr_q & GMASK_V) != '0 || addr_q >= top_q) begin
          res_d = '0; st_d = ST_DFREE; state_d = S_DONE;
        end else begin
          blk_d = arsp.diff; mreq.re = 1'b1; mreq.addr = arsp.diff; state_d = S_F_SZ;
        end
      end
      S_F_SZ: begin
        sz_d = rd_v; mreq.re = 1'b1; mreq.addr = blk_q | HI_V; state_d = S_F_FL;
      end
      S_F_FL: begin
        fl_d = rdata[2:0];
        areq.a = blk_q; areq.b = sz_q;
        nx_d = arsp.sum;
        if (!rdata[0] || sz_q < MINB_V || (sz_q & GMASK_V) != '0 || arsp.sum > top_q) begin
          res_d = '0; st_d = ST_DFREE; state_d = S_DONE;
        end else begin
          state_d = S_F_NX;
        end
      end
      S_F_NX: begin
        if (nx_q < top_q) begin
          mreq.re = 1'b1; mreq.addr = nx_q | HI_V; state_d = S_F_NFL;
        end else begin
          state_d = S_F_PV;
        end
      end
      S_F_NFL: begin
        nfl_d = rdata[0]; mreq.re = 1'b1; mreq.addr = nx_q; state_d = S_F_NSZ;
      end
      S_F_NSZ: begin
        nsz_d = rd_v;
        areq.a = nx_q; areq.b = rd_v;
        if (!nfl_q && rd_v >= MINB_V && (rd_v & GMASK_V) == '0 && arsp.sum <= top_q) begin
          state_d = S_F_MRG;
        end else begin
          state_d = S_F_PV;
        end
      end
      S_F_MRG: begin
        areq.a = sz_q; areq.b = nsz_q;
        sz_d = arsp.sum;
        mreq.we = 1'b1; mreq.addr = blk_q; mreq.wdata = DW'(arsp.sum);
        ul_n_d = AW'(nx_q + HDR_V); ul_ret_d = S_F_PV; state_d = S_UL0;
      end
      S_F_PV: begin
        if ((fl_q & F_PREV) != '0) begin
          areq.a = blk_q; areq.b = HDR_V;
          mreq.re = 1'b1; mreq.addr = arsp.diff; state_d = S_F_PSZ;
        end else begin
          state_d = S_F_CLR;
        end
      end
      S_F_PSZ: begin
        areq.a = blk_q; areq.b = rd_v;
        if (rd_v >= MINB_V && (rd_v & GMASK_V) == '0 && !arsp.lt) begin
          blk_d = arsp.diff; state_d = S_F_PRD;
        end else begin
          state_d = S_F_CLR;
        end
      end
      S_F_PRD: begin
        mreq.re = 1'b1; mreq.addr = blk_q; state_d = S_F_PWR;
      end
      S_F_PWR: begin
        areq.a = rd_v; areq.b = sz_q;
        mreq.we = 1'b1; mreq.addr = blk_q; mreq.wdata = DW'(arsp.sum);
        ul_n_d = AW'(blk_q + HDR_V); ul_ret_d = S_F_CLR; state_d = S_UL0;
      end
      S_F_CLR: begin
        mreq.re = 1'b1; mreq.addr = blk_q | HI_V; state_d = S_F_CLW;
      end
      S_F_CLW: begin
        mreq.we = 1'b1; mreq.addr = blk_q | HI_V; mreq.wdata = rdata & ~DW'(F_ALLOC);
        ins_b_d = blk_q; ins_ret_d = S_FIN; state_d = S_IN0;
      end
      S_FIN: begin
        res_d = '0; st_d = ST_OK; state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.result_address = res_q;
          out_d.status = st_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      // footer copy of block cf_b
      S_CF0: begin
        mreq.re = 1'b1; mreq.addr = cf_b_q; state_d = S_CF1;
      end
      S_CF1: begin
        cf_sz_d = rd_v; mreq.re = 1'b1; mreq.addr = cf_b_q | HI_V; state_d = S_CF2;
      end
      S_CF2: begin
        cf_fl_d = rdata[2:0];
        areq.a = cf_b_q; areq.b = cf_sz_q;
        cf_fa_d = arsp.sum - HDR_V;
        mreq.we = 1'b1; mreq.addr = arsp.sum - HDR_V; mreq.wdata = DW'(cf_sz_q);
        state_d = S_CF3;
      end
      S_CF3: begin
        mreq.we = 1'b1; mreq.addr = cf_fa_q | HI_V; mreq.wdata = DW'(cf_fl_q);
        state_d = cf_ret_q;
      end
      // unlink list node ul_n
      S_UL0: begin
        mreq.re = 1'b1; mreq.addr = VW'(ul_n_q); state_d = S_UL1;
      end
      S_UL1: begin
        ul_p_d = rdata[AW-1:0]; mreq.re = 1'b1; mreq.addr = VW'(ul_n_q) | HI_V;
        state_d = S_UL2;
      end
      S_UL2: begin
        ul_x_d = rdata[AW-1:0];
        if (ul_p_q != '0) begin
          mreq.we = 1'b1; mreq.addr = VW'(ul_p_q) | HI_V; mreq.wdata = DW'(rdata[AW-1:0]);
        end else begin
          head_d = rdata[AW-1:0];
        end
        state_d = S_UL3;
      end
      S_UL3: begin
        if (ul_x_q != '0) begin
          mreq.we = 1'b1; mreq.addr = VW'(ul_x_q); mreq.wdata = DW'(ul_p_q);
        end
        state_d = S_UL4;
      end
      S_UL4: begin
        mreq.we = 1'b1; mreq.addr = VW'(ul_n_q); mreq.wdata = '0; state_d = S_UL5;
      end
      S_UL5: begin
        mreq.we = 1'b1; mreq.addr = VW'(ul_n_q) | HI_V; mreq.wdata = '0;
        state_d = ul_ret_q;
      end
      // push block ins_b on the list head
      S_IN0: begin
        areq.a = ins_b_q; areq.b = HDR_V;
        mreq.we = 1'b1; mreq.addr = arsp.sum; mreq.wdata = '0; state_d = S_IN1;
      end
      S_IN1: begin
        areq.a = ins_b_q; areq.b = HDR_V;
        mreq.we = 1'b1; mreq.addr = arsp.sum | HI_V; mreq.wdata = DW'(head_q);
        state_d = S_IN2;
      end
      S_IN2: begin
        areq.a = ins_b_q; areq.b = HDR_V;
        if (head_q != '0) begin
          mreq.we = 1'b1; mreq.addr = VW'(head_q); mreq.wdata = DW'(arsp.sum);
        end
        head_d = arsp.sum[AW-1:0];
        cf_b_d = ins_b_q; cf_ret_d = S_IN3; state_d = S_CF0;
      end
      S_IN3: begin
        mreq.re = 1'b1; mreq.addr = ins_b_q; state_d = S_IN4;
      end
      S_IN4: begin
        areq.a = ins_b_q; areq.b = rd_v; nx_d = arsp.sum; state_d = S_IN5;
      end
      S_IN5: begin
        if (nx_q < top_q) begin
          mreq.re = 1'b1; mreq.addr = nx_q | HI_V; state_d = S_IN6;
        end else begin
          state_d = ins_ret_q;
        end
      end
      S_IN6: begin
        mreq.we = 1'b1; mreq.addr = nx_q | HI_V; mreq.wdata = rdata | DW'(F_PREV);
        state_d = ins_ret_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("took a second request while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.result_address == '0)
    else $error("failed request returned an address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= HEAP_V && (top_q & GMASK_V) == '0)
    else $error("arena top out of range or misaligned");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (VW'(head_q) & GMASK_V) == '0)
    else $error("free list head misaligned");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.re |-> !mreq.we)
    else $error("heap ram read and write in one cycle");

endmodule

### src/bta_alu.sv
module bta_alu (
  input  bta_pkg::alu_req_t req_i,
  output bta_pkg::alu_rsp_t rsp_o
);
  import bta_pkg::*;

  assign rsp_o.sum  = req_i.a + req_i.b;
  assign rsp_o.diff = req_i.a - req_i.b;
  assign rsp_o.lt   = req_i.a < req_i.b;

endmodule

### src/bta_heap_ram.sv
module bta_heap_ram (
  input  logic                   clk_i,
  input  bta_pkg::mem_req_t      req_i,
  output logic [bta_pkg::DW-1:0] rdata_o
);
  import bta_pkg::*;

  logic [DW-1:0] mem_q [WORDS];
  logic [DW-1:0] rdata_q;
  logic          in_range;

  // words past the heap read as zero and drop writes
  assign in_range = req_i.addr < HEAP_V;

  always_ff @(posedge clk_i) begin
    if (req_i.we && in_range) begin
      mem_q[req_i.addr[WIDX+2:3]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= in_range ? mem_q[req_i.addr[WIDX+2:3]] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule
